// ===== design/esd_pkg.sv =====
// shared types, constants and helpers of the escape sequence decoder
package esd_pkg;

  localparam int CharBits = 16;
  localparam int FieldBits = 16;
  localparam int AddrBits = 1;
  localparam int DataBits = 32;

  typedef logic [FieldBits-1:0] field_t;
  typedef logic [CharBits-1:0] char_t;
  typedef logic [1:0] phase_t;

  localparam phase_t PhPlain = 2'd0;
  localparam phase_t PhEsc = 2'd1;
  localparam phase_t PhHex = 2'd2;

  localparam logic [AddrBits-1:0] RegRegexpMode = 1'b0;

  localparam char_t ChBslash = char_t'(16'h005C);
  localparam char_t ChLowF = char_t'(16'h0066);
  localparam char_t ChLowN = char_t'(16'h006E);
  localparam char_t ChLowR = char_t'(16'h0072);
  localparam char_t ChLowT = char_t'(16'h0074);
  localparam char_t ChLowV = char_t'(16'h0076);
  localparam char_t ChLowX = char_t'(16'h0078);
  localparam char_t ChUpX = char_t'(16'h0058);
  localparam char_t ChFormFeed = char_t'(16'h000C);
  localparam char_t ChLineFeed = char_t'(16'h000A);
  localparam char_t ChCarRet = char_t'(16'h000D);
  localparam char_t ChHorTab = char_t'(16'h0009);
  localparam char_t ChVerTab = char_t'(16'h000B);

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input char_t c);
    hex_digit_t r;
    r.ok = 1'b1;
    r.val = 4'd0;
    if (c >= char_t'(16'h0030) && c <= char_t'(16'h0039)) begin
      r.val = c[3:0];
    end else if ((c >= char_t'(16'h0061) && c <= char_t'(16'h0066)) ||
                 (c >= char_t'(16'h0041) && c <= char_t'(16'h0046))) begin
      r.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic field_t to_field(input char_t c);
    return field_t'(c);
  endfunction

endpackage

// ===== design/esd_in_if.sv =====
// request and result channel interfaces of the escape sequence decoder
interface esd_in_if;
  logic            valid;
  logic            ready;
  esd_pkg::field_t in_char;
  logic            in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink (input valid, input in_char, input in_last, output ready);
endinterface

interface esd_out_if;
  logic            valid;
  logic            ready;
  esd_pkg::field_t out_char;
  logic            out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

// ===== design/escape_sequence_decoder_core.sv =====
// escape sequence decoder top level
//
// in_chan takes one character request per cycle while it is ready (in_char,
// in_last marks the end of a string). out_chan gives decoded characters in
// order, out_last set on the final character caused by an input request
// with in_last. An APB-style port holds one register, regexp_mode at
// address 0; the user must write it only while no request is in flight;
// the block does not enforce this. Each accepted request is decoded in the
// cycle it is accepted into a result buffer of up to three characters; the
// first result shows on out_chan in the cycle after acceptance. A request
// that gives zero or one character lets the next request enter in the
// following cycle while out_chan is ready, so plain text flows at one
// character per cycle when out_chan does not stall. A request that gives
// two or three characters holds in_chan while the buffer drains through its
// single output port. When out_chan stalls, the buffer holds its characters
// and in_chan is stalled while a character waits on the stalled out_chan.
// Reset clears regexp_mode, the decoder state (plain text phase) and the
// buffer fill count; it takes requests in the first cycle after reset.
module escape_sequence_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  esd_in_if.sink                        in_chan,
  esd_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [esd_pkg::AddrBits-1:0]  paddr,
  input  logic [esd_pkg::DataBits-1:0]  pwdata,
  output logic [esd_pkg::DataBits-1:0]  prdata,
  output logic                          pready
);
  import esd_pkg::*;

  logic       regexp_q, regexp_d;
  phase_t     phase_q, phase_d;
  logic       wide_q, wide_d;
  logic [2:0] cnt_q, cnt_d;
  logic [15:0] hex_q, hex_d;

  char_t      buf_q [3];
  char_t      buf_d [3];
  logic [1:0] fill_q, fill_d;
  logic       last_q, last_d;

  char_t      res [3];
  logic [1:0] nres;
  char_t      c;
  logic       lst;
  logic       acc, pop;
  hex_digit_t hd;
  logic [15:0] hex_n;
  logic [2:0] cnt_n;
  logic [2:0] maxd;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr == RegRegexpMode) ? DataBits'(regexp_q) : '0;

  always_comb begin
    regexp_d = regexp_q;
    if (psel && penable && pwrite && (paddr == RegRegexpMode)) begin
      regexp_d = pwdata[0];
    end
  end

  // handshakes
  assign in_chan.ready = (fill_q == 2'd0) || ((fill_q == 2'd1) && out_chan.ready);
  assign acc = in_chan.valid && in_chan.ready;
  assign out_chan.valid = (fill_q != 2'd0);
  assign pop = out_chan.valid && out_chan.ready;
  assign out_chan.out_char = to_field(buf_q[0]);
  assign out_chan.out_last = last_q && (fill_q == 2'd1);

  assign c = in_chan.in_char[CharBits-1:0];
  assign lst = in_chan.in_last;
  assign hd = hex_digit(c);
  assign hex_n = {hex_q[11:0], hd.val};
  assign cnt_n = cnt_q + 3'd1;
  assign maxd = wide_q ? 3'd4 : 3'd2;

  // decode
  always_comb begin
    phase_d = phase_q;
    wide_d = wide_q;
    cnt_d = cnt_q;
    hex_d = hex_q;
    nres = 2'd0;
    res[0] = c;
    res[1] = c;
    res[2] = c;
    if (acc) begin
      case (phase_q)
        PhEsc: begin
          phase_d = PhPlain;
          nres = 2'd1;
          case (c)
            ChBslash: begin
              res[0] = ChBslash;
              res[1] = ChBslash;
              nres = regexp_q ? 2'd2 : 2'd1;
            end
            ChLowF: res[0] = ChFormFeed;
            ChLowN: res[0] = ChLineFeed;
            ChLowR: res[0] = ChCarRet;
            ChLowT: res[0] = ChHorTab;
            ChLowV: res[0] = ChVerTab;
            ChLowX, ChUpX: begin
              if (lst) begin
                res[0] = ChBslash;
                res[1] = c;
                nres = 2'd2;
              end else begin
                nres = 2'd0;
                phase_d = PhHex;
                wide_d = (c == ChUpX);
                cnt_d = 3'd0;
                hex_d = 16'd0;
              end
            end
            default: begin
              res[0] = ChBslash;
              res[1] = c;
              nres = 2'd2;
            end
          endcase
        end
        PhHex: begin
          if (hd.ok) begin
            if (cnt_n >= maxd || lst) begin
              res[0] = hex_n[CharBits-1:0];
              nres = 2'd1;
              phase_d = PhPlain;
              cnt_d = 3'd0;
              hex_d = 16'd0;
            end else begin
              cnt_d = cnt_n;
              hex_d = hex_n;
            end
          end else begin
            phase_d = PhPlain;
            cnt_d = 3'd0;
            hex_d = 16'd0;
            if (cnt_q == 3'd0) begin
              res[0] = ChBslash;
              res[1] = wide_q ? ChUpX : ChLowX;
              if (c == ChBslash && !lst) begin
                phase_d = PhEsc;
                nres = 2'd2;
              end else begin
                res[2] = c;
                nres = 2'd3;
              end
            end else begin
              res[0] = hex_q[CharBits-1:0];
              if (c == ChBslash && !lst) begin
                phase_d = PhEsc;
                nres = 2'd1;
              end else begin
                res[1] = c;
                nres = 2'd2;
              end
            end
          end
        end
        default: begin
          phase_d = PhPlain;
          if (c == ChBslash && !lst) begin
            phase_d = PhEsc;
          end else begin
            nres = 2'd1;
          end
        end
      endcase
    end
  end

  // result buffer
  always_comb begin
    buf_d = buf_q;
    fill_d = fill_q;
    last_d = last_q;
    if (acc) begin
      buf_d = res;
      fill_d = nres;
      last_d = lst;
    end else if (pop) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regexp_q <= 1'b0;
      phase_q <= PhPlain;
      wide_q <= 1'b0;
      cnt_q <= 3'd0;
      hex_q <= 16'd0;
      fill_q <= 2'd0;
      last_q <= 1'b0;
    end else begin
      regexp_q <= regexp_d;
      phase_q <= phase_d;
      wide_q <= wide_d;
      cnt_q <= cnt_d;
      hex_q <= hex_d;
      fill_q <= fill_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  a_last_ends_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && lst) |=> (phase_q == PhPlain))
    else $error("string end left decoder outside plain text");

  a_hex_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhHex) |-> (cnt_q < maxd))
    else $error("hex run holds too many digits");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhPlain || phase_q == PhEsc || phase_q == PhHex))
    else $error("unused phase code");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !acc && fill_q == 2'd1) |=> (fill_q == 2'd0))
    else $error("buffer did not drain");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan.valid && !out_chan.ready) |=> ($stable(buf_q[0]) && fill_q != 2'd0))
    else $error("stalled result changed");

endmodule

// ===== sim/escape_sequence_decoder_checker.sv =====
// checker for the escape sequence decoder: predicts decoded characters and compares results
module escape_sequence_decoder_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  esd_in_if                            req_i,
  esd_out_if                           rsp_i,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [esd_pkg::AddrBits-1:0] paddr,
  input  logic [esd_pkg::DataBits-1:0] pwdata,
  output int                           mismatch_cnt_o,
  output int                           chars_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import esd_pkg::*;

  typedef struct packed {
    char_t ch;
    logic  last;
  } decoded_t;

  decoded_t   chars_due[$];
  char_t      emitted[$];
  logic       regexp_on;
  phase_t     phase;
  logic       wide_run;
  logic [2:0] digits;
  char_t      run_value;
  int         errs;

  function automatic logic hex_nibble(input char_t c, output logic [3:0] nib);
    nib = 4'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      nib = 4'(c - 16'h0030);
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      nib = 4'(c - 16'h0057);
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      nib = 4'(c - 16'h0037);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_plain(input char_t c, input logic last);
    if (c == ChBslash && !last) begin
      phase = PhEsc;
    end else begin
      emitted.push_back(c);
    end
  endfunction

  function automatic void decode_char(input char_t c, input logic last);
    logic [3:0] nib;
    logic       is_digit;
    emitted.delete();
    case (phase)
      PhEsc: begin
        phase = PhPlain;
        if (c == ChBslash) begin
          if (regexp_on) emitted.push_back(ChBslash);
          emitted.push_back(ChBslash);
        end else if (c == ChLowF) begin
          emitted.push_back(ChFormFeed);
        end else if (c == ChLowN) begin
          emitted.push_back(ChLineFeed);
        end else if (c == ChLowR) begin
          emitted.push_back(ChCarRet);
        end else if (c == ChLowT) begin
          emitted.push_back(ChHorTab);
        end else if (c == ChLowV) begin
          emitted.push_back(ChVerTab);
        end else if ((c == ChLowX || c == ChUpX) && !last) begin
          phase = PhHex;
          wide_run = (c == ChUpX);
          digits = 3'd0;
          run_value = '0;
        end else begin
          emitted.push_back(ChBslash);
          emitted.push_back(c);
        end
      end
      PhHex: begin
        is_digit = hex_nibble(c, nib);
        if (is_digit) begin
          run_value = {run_value[CharBits-5:0], nib};
          digits = digits + 3'd1;
          if (digits >= (wide_run ? 3'd4 : 3'd2) || last) begin
            emitted.push_back(run_value);
            phase = PhPlain;
            digits = 3'd0;
            run_value = '0;
          end
        end else begin
          if (digits == 3'd0) begin
            emitted.push_back(ChBslash);
            emitted.push_back(wide_run ? ChUpX : ChLowX);
          end else begin
            emitted.push_back(run_value);
          end
          phase = PhPlain;
          digits = 3'd0;
          run_value = '0;
          take_plain(c, last);
        end
      end
      default: begin
        phase = PhPlain;
        take_plain(c, last);
      end
    endcase
    foreach (emitted[i]) begin
      chars_due.push_back('{ch: emitted[i], last: last && (i == emitted.size() - 1)});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    if (!rst_ni) begin
      regexp_on = 1'b0;
      phase = PhPlain;
      wide_run = 1'b0;
      digits = 3'd0;
      run_value = '0;
      errs = 0;
      chars_due.delete();
      mismatch_cnt_o <= 0;
      chars_pending_o <= 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        decode_char(char_t'(req_i.in_char), req_i.in_last);
      end
      if (psel && penable && pwrite && pready && paddr == RegRegexpMode) begin
        regexp_on = pwdata[0];
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (chars_due.size() == 0) begin
          $error("out_char: expected nothing, got %h", rsp_i.out_char);
          errs++;
        end else begin
          want = chars_due.pop_front();
          if (char_t'(rsp_i.out_char) !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, rsp_i.out_char);
            errs++;
          end
          if (rsp_i.out_last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, rsp_i.out_last);
            errs++;
          end
        end
      end
      mismatch_cnt_o <= errs;
      chars_pending_o <= chars_due.size();
    end
  end

endmodule

// ===== sim/escape_sequence_decoder_core_test.sv =====
// testbench top for the escape sequence decoder: stimulus, register writes and verdict
module escape_sequence_decoder_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import esd_pkg::*;

  localparam int HoldCycles = 80;
  localparam int DrainCycles = 4;
  localparam int QuietLimit = 1000;
  localparam char_t NearDigits[6] = '{16'h002F, 16'h003A, 16'h0040, 16'h0047,
                                      16'h0060, 16'h0067};
  localparam char_t EscLetters[8] = '{ChLowF, ChLowN, ChLowR, ChLowT, ChLowV,
                                      ChLowX, ChUpX, ChBslash};

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [DataBits-1:0] pwdata;
  logic [DataBits-1:0] prdata;
  logic                pready;
  int                  mismatch_cnt;
  int                  chars_pending;
  int                  items_sent;
  int                  quiet_cycles;
  bit                  steady;
  bit                  hold_start;

  esd_in_if  req_chan ();
  esd_out_if rsp_chan ();

  escape_sequence_decoder_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (req_chan),
    .out_chan (rsp_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  escape_sequence_decoder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_chan),
    .rsp_i           (rsp_chan),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .mismatch_cnt_o  (mismatch_cnt),
    .chars_pending_o (chars_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic char_t any_hex_digit();
    case ($urandom_range(2))
      0: return char_t'(16'h0030 + $urandom_range(9));
      1: return char_t'(16'h0061 + $urandom_range(5));
      default: return char_t'(16'h0041 + $urandom_range(5));
    endcase
  endfunction

  function automatic char_t any_char();
    case ($urandom_range(9))
      0, 1: return char_t'($urandom);
      2: return ChBslash;
      3: return EscLetters[$urandom_range(7)];
      4: return any_hex_digit();
      5: return NearDigits[$urandom_range(5)];
      default: return char_t'($urandom_range(16'h007E, 16'h0020));
    endcase
  endfunction

  function automatic logic coin_last();
    return $urandom_range(11) == 0;
  endfunction

  task automatic send_item(input char_t c, input logic last);
    while (!steady && $urandom_range(99) < 20) begin
      req_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_chan.valid <= 1'b1;
    req_chan.in_char <= c;
    req_chan.in_last <= last;
    do @(posedge clk_i); while (!req_chan.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit end_mark);
    for (int i = 0; i < s.len(); i++) begin
      send_item(char_t'(s[i]), end_mark && i == s.len() - 1);
    end
  endtask

  task automatic send_random_piece();
    int unsigned n;
    case ($urandom_range(9))
      0, 1: send_item(any_char(), coin_last());
      2, 3: begin
        send_item(ChBslash, coin_last());
        send_item($urandom_range(1) ? EscLetters[$urandom_range(7)] : any_char(),
                  coin_last());
      end
      default: begin
        n = $urandom_range(5);
        send_item(ChBslash, coin_last());
        send_item($urandom_range(1) ? ChUpX : ChLowX, coin_last());
        repeat (n) send_item(any_hex_digit(), coin_last());
        if ($urandom_range(1)) send_item(any_char(), coin_last());
      end
    endcase
  endtask

  task automatic run_random(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) send_random_piece();
  endtask

  // stop offering requests and wait until every decoded character is out
  task automatic settle();
    req_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_regexp(input logic mode);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RegRegexpMode;
    pwdata <= {(DataBits-1)'($urandom), mode};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int unsigned stall;
    rsp_chan.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        rsp_chan.ready <= 1'b0;
        stall = 0;
        while (stall < HoldCycles) begin
          @(posedge clk_i);
          stall++;
        end
      end
      rsp_chan.ready <= steady || $urandom_range(99) >= 20;
    end
  end

  always @(posedge clk_i) begin
    if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || psel ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    quiet_cycles = 0;
    items_sent = 0;
    steady = 1'b0;
    hold_start = 1'b0;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    req_chan.valid <= 1'b0;
    req_chan.in_char <= '0;
    req_chan.in_last <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_regexp(1'b0);
    send_item(char_t'(16'hFFFF), 1'b0);
    send_item(char_t'(16'h0000), 1'b1);
    send_text("\\f\\n\\r\\t\\v", 1'b0);
    send_text("\\\\", 1'b0);
    send_text("\\xA\\q", 1'b0);
    send_text("\\xFf", 1'b0);
    send_text("\\xq", 1'b0);
    send_text("\\", 1'b1);
    settle();

    write_regexp(1'b1);
    send_text("\\\\a\\\\", 1'b1);
    hold_start = 1'b1;
    run_random(70);
    settle();

    write_regexp(1'b0);
    steady = 1'b1;
    run_random(60);
    steady = 1'b0;
    settle();

    write_regexp(1'b1);
    run_random(60);
    settle();

    if (mismatch_cnt == 0 && chars_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/esd_pkg.sv
design/esd_in_if.sv
design/escape_sequence_decoder_core.sv
sim/escape_sequence_decoder_checker.sv
sim/escape_sequence_decoder_core_test.sv
